// ----- design/blda_pkg.sv -----
// Shared types, widths and register indexes for the block-linear deswizzle
// address generator. No dependencies; used by every blda module and the top.
`timescale 1ns / 1ps

package blda_pkg;

  // Address and field widths
  localparam int ADDR_BITS_DEF = 44;
  localparam int ADDR_FIELD_W  = 44;
  localparam int FULL_W        = 48;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 44;

  // Request queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Internal arithmetic widths
  localparam int XB_W    = 19;
  localparam int ZH_W    = 26;
  localparam int ZHY_W   = 27;
  localparam int WB_W    = 20;
  localparam int GPR_W   = 14;
  localparam int HAL_W   = 16;
  localparam int SLICE_W = 36;
  localparam int YQ_W    = 11;
  localparam int GOB_W   = 30;
  localparam int LIN_W   = ZHY_W + WB_W;
  localparam int SLAB_W  = 11 + SLICE_W;
  localparam int YG_W    = YQ_W + GPR_W;

  // GOB geometry
  localparam int GOB_ROW_LOG2    = 6;
  localparam int PITCH_ALIGN_LOG2 = 5;
  localparam int GOB_BYTES_LOG2  = 9;
  localparam int GOB_ROWS_LOG2   = 3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LAYOUT_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_BLOCKS    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_BLOCKS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLICE_COUNT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_BLOCK = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GOB_STACK_LOG2  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_BYTES    = 3'd6;

  // Layout modes
  localparam logic LAYOUT_BLOCK = 1'b0;
  localparam logic LAYOUT_PITCH = 1'b1;

  typedef struct packed {
    logic [13:0] block_x;
    logic [13:0] block_y;
    logic [10:0] slice_z;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_FIELD_W-1:0] src_address;
    logic [ADDR_FIELD_W-1:0] dst_address;
    logic [4:0]              copy_bytes;
  } out_item_t;

  typedef struct packed {
    logic        layout_mode;
    logic [14:0] width_blocks;
    logic [14:0] height_blocks;
    logic [11:0] slice_count;
    logic [4:0]  bytes_per_block;
    logic [2:0]  gob_stack_log2;
    logic [43:0] source_bytes;
  } cfg_t;

  typedef struct packed {
    logic [WB_W-1:0]    wb;
    logic [GPR_W-1:0]   gpr;
    logic [WB_W-1:0]    pitch;
    logic [SLICE_W-1:0] slice_size;
  } geom_t;

  typedef struct packed {
    logic            in_range;
    logic [XB_W-1:0] xb;
    logic [ZH_W-1:0] zh;
    logic [13:0]     block_y;
    logic [10:0]     slice_z;
  } q_item_t;

endpackage

// ----- design/blda_cfg.sv -----
// Configuration registers and derived surface geometry (row size, pitch,
// slice size). Depends on blda_pkg.
`timescale 1ns / 1ps

module blda_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [blda_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [blda_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output blda_pkg::cfg_t                   cfg,
  output blda_pkg::geom_t                  geom
);

  blda_pkg::cfg_t cfg_r;

  logic [blda_pkg::WB_W-1:0]    wb_r, wb_nxt;
  logic [blda_pkg::HAL_W-1:0]   h_al_r, h_al_nxt;
  logic [blda_pkg::WB_W-1:0]    row_bytes_r, row_bytes_nxt;
  logic [blda_pkg::WB_W-1:0]    pitch_r, pitch_nxt;
  logic [blda_pkg::GPR_W-1:0]   gpr_r, gpr_nxt;
  logic [blda_pkg::SLICE_W-1:0] slice_size_r, slice_size_nxt;

  logic [blda_pkg::HAL_W-1:0] amask;
  logic [blda_pkg::HAL_W-1:0] h_sum;
  logic [blda_pkg::WB_W:0]    row_sum;
  logic [blda_pkg::WB_W:0]    pitch_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.layout_mode     <= blda_pkg::LAYOUT_BLOCK;
      cfg_r.width_blocks    <= 15'd1;
      cfg_r.height_blocks   <= 15'd1;
      cfg_r.slice_count     <= 12'd1;
      cfg_r.bytes_per_block <= 5'd4;
      cfg_r.gob_stack_log2  <= 3'd0;
      cfg_r.source_bytes    <= 44'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        blda_pkg::REG_LAYOUT_MODE:     cfg_r.layout_mode     <= cfg_wdata[0];
        blda_pkg::REG_WIDTH_BLOCKS:    cfg_r.width_blocks    <= cfg_wdata[14:0];
        blda_pkg::REG_HEIGHT_BLOCKS:   cfg_r.height_blocks   <= cfg_wdata[14:0];
        blda_pkg::REG_SLICE_COUNT:     cfg_r.slice_count     <= cfg_wdata[11:0];
        blda_pkg::REG_BYTES_PER_BLOCK: cfg_r.bytes_per_block <= cfg_wdata[4:0];
        blda_pkg::REG_GOB_STACK_LOG2:  cfg_r.gob_stack_log2  <= cfg_wdata[2:0];
        blda_pkg::REG_SOURCE_BYTES:    cfg_r.source_bytes    <= cfg_wdata[43:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    wb_nxt   = blda_pkg::WB_W'(cfg_r.width_blocks) * blda_pkg::WB_W'(cfg_r.bytes_per_block);
    amask    = (blda_pkg::HAL_W'(8) << cfg_r.gob_stack_log2) - blda_pkg::HAL_W'(1);
    h_sum    = blda_pkg::HAL_W'(cfg_r.height_blocks) + amask;
    h_al_nxt = h_sum & ~amask;

    row_sum       = (blda_pkg::WB_W+1)'(wb_r) + (blda_pkg::WB_W+1)'(63);
    row_bytes_nxt = {row_sum[blda_pkg::WB_W-1:blda_pkg::GOB_ROW_LOG2],
                     blda_pkg::GOB_ROW_LOG2'(0)};
    gpr_nxt       = row_sum[blda_pkg::WB_W-1:blda_pkg::GOB_ROW_LOG2];
    pitch_sum     = (blda_pkg::WB_W+1)'(wb_r) + (blda_pkg::WB_W+1)'(31);
    pitch_nxt     = {pitch_sum[blda_pkg::WB_W-1:blda_pkg::PITCH_ALIGN_LOG2],
                     blda_pkg::PITCH_ALIGN_LOG2'(0)};

    slice_size_nxt = blda_pkg::SLICE_W'(row_bytes_r) * blda_pkg::SLICE_W'(h_al_r);
  end

  // Geometry follows the registers each cycle
  always_ff @(posedge clk) begin
    wb_r         <= wb_nxt;
    h_al_r       <= h_al_nxt;
    row_bytes_r  <= row_bytes_nxt;
    gpr_r        <= gpr_nxt;
    pitch_r      <= pitch_nxt;
    slice_size_r <= slice_size_nxt;
  end

  assign cfg = cfg_r;
  assign geom = '{wb: wb_r, gpr: gpr_r, pitch: pitch_r, slice_size: slice_size_r};

endmodule

// ----- design/blda_front.sv -----
// Front end: accepts requests, checks surface bounds and forms the first
// products for the queue. Depends on blda_pkg.
`timescale 1ns / 1ps

module blda_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  blda_pkg::in_item_t           in_data,
  input  blda_pkg::cfg_t               cfg,
  input  logic [blda_pkg::Q_CNT_W-1:0] q_count,
  output logic                         push,
  output blda_pkg::q_item_t            push_data
);

  logic               f1_v_r, f1_v_nxt;
  blda_pkg::in_item_t f1_item_r;
  logic               f2_v_r, f2_v_nxt;
  blda_pkg::q_item_t  f2_item_r, f2_item_nxt;

  logic [blda_pkg::Q_CNT_W:0] occ;
  logic [11:0]                slices_eff;
  logic                       accept;

  always_comb begin
    occ = (blda_pkg::Q_CNT_W+1)'(q_count) + (blda_pkg::Q_CNT_W+1)'(f1_v_r)
        + (blda_pkg::Q_CNT_W+1)'(f2_v_r);
    busy   = occ >= (blda_pkg::Q_CNT_W+1)'(blda_pkg::Q_DEPTH);
    accept = start & ~busy;

    f1_v_nxt = accept;
    f2_v_nxt = f1_v_r;

    slices_eff = (cfg.slice_count == 12'd0) ? 12'd1 : cfg.slice_count;
    f2_item_nxt.in_range = ({1'b0, f1_item_r.block_x} < cfg.width_blocks)
                        && ({1'b0, f1_item_r.block_y} < cfg.height_blocks)
                        && ({1'b0, f1_item_r.slice_z} < slices_eff);
    f2_item_nxt.xb = blda_pkg::XB_W'(f1_item_r.block_x)
                   * blda_pkg::XB_W'(cfg.bytes_per_block);
    f2_item_nxt.zh = blda_pkg::ZH_W'(f1_item_r.slice_z)
                   * blda_pkg::ZH_W'(cfg.height_blocks);
    f2_item_nxt.block_y = f1_item_r.block_y;
    f2_item_nxt.slice_z = f1_item_r.slice_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      f1_v_r <= f1_v_nxt;
      f2_v_r <= f2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_item_r <= in_data;
    end
    f2_item_r <= f2_item_nxt;
  end

  assign push      = f2_v_r;
  assign push_data = f2_item_r;

endmodule

// ----- design/blda_queue.sv -----
// Short request queue between front and back end, drained one request per
// cycle. Depends on blda_pkg.
`timescale 1ns / 1ps

module blda_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  blda_pkg::q_item_t            push_data,
  output logic [blda_pkg::Q_CNT_W-1:0] q_count,
  output logic                         pop_valid,
  output blda_pkg::q_item_t            pop_data
);

  blda_pkg::q_item_t mem [blda_pkg::Q_DEPTH];

  logic [blda_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [blda_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [blda_pkg::Q_CNT_W-1:0] count_r, count_nxt;
  logic                         rd_valid_r;
  blda_pkg::q_item_t            rd_data_r;
  logic                         pop;

  always_comb begin
    pop        = count_r != '0;
    wr_ptr_nxt = push ? wr_ptr_r + blda_pkg::Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + blda_pkg::Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + blda_pkg::Q_CNT_W'(push) - blda_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      count_r    <= count_nxt;
      rd_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign q_count   = count_r;
  assign pop_valid = rd_valid_r;
  assign pop_data  = rd_data_r;

endmodule

// ----- design/blda_back.sv -----
// Back end: GOB and pitch address pipeline, bounds test against the source
// size and the result register. Depends on blda_pkg.
`timescale 1ns / 1ps

module blda_back #(
  parameter int ADDR_BITS = blda_pkg::ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  blda_pkg::cfg_t      cfg,
  input  blda_pkg::geom_t     geom,
  input  logic                pop_valid,
  input  blda_pkg::q_item_t   pop_data,
  output logic                out_strobe,
  output blda_pkg::out_item_t out_data
);

  localparam int OUT_BITS = (ADDR_BITS < blda_pkg::ADDR_FIELD_W) ? ADDR_BITS
                                                                 : blda_pkg::ADDR_FIELD_W;
  localparam logic [blda_pkg::ADDR_FIELD_W-1:0] ADDR_MASK =
    {blda_pkg::ADDR_FIELD_W{1'b1}} >> (blda_pkg::ADDR_FIELD_W - OUT_BITS);

  // Stage 1
  logic                       b1_v_r;
  logic                       b1_ok_r;
  logic [blda_pkg::ZHY_W-1:0] b1_zhy_r, b1_zhy_nxt;
  logic [blda_pkg::YQ_W-1:0]  b1_yq_r, b1_yq_nxt;
  logic [10:0]                b1_z_r;
  logic [blda_pkg::XB_W-1:0]  b1_xb_r;
  logic [blda_pkg::GOB_W-1:0] b1_gob_r, b1_gob_nxt;

  // Stage 2
  logic                        b2_v_r;
  logic                        b2_ok_r;
  logic [blda_pkg::LIN_W-1:0]  b2_dst_m_r, b2_dst_m_nxt;
  logic [blda_pkg::LIN_W-1:0]  b2_pitch_m_r, b2_pitch_m_nxt;
  logic [blda_pkg::SLAB_W-1:0] b2_slab_m_r, b2_slab_m_nxt;
  logic [blda_pkg::YG_W-1:0]   b2_yg_m_r, b2_yg_m_nxt;
  logic [blda_pkg::XB_W-1:0]   b2_xb_r;
  logic [blda_pkg::GOB_W-1:0]  b2_gob_r;

  // Stage 3
  logic                        b3_v_r;
  logic                        b3_ok_r;
  logic [blda_pkg::FULL_W-1:0] b3_src_r, b3_src_nxt;
  logic [blda_pkg::FULL_W-1:0] b3_dst_r, b3_dst_nxt;

  // Result
  logic                out_strobe_r;
  blda_pkg::out_item_t out_data_r, out_data_nxt;

  logic [3:0]                  sh_lo;
  logic [4:0]                  sh_hi;
  logic [blda_pkg::YQ_W-1:0]   ymask;
  logic [blda_pkg::YQ_W-1:0]   ymid;
  logic [blda_pkg::GOB_W-1:0]  term2;
  logic [blda_pkg::GOB_W-1:0]  term3;
  logic [8:0]                  low9;
  logic [blda_pkg::FULL_W-1:0] ygs;
  logic [blda_pkg::FULL_W-1:0] size_ext;
  logic [blda_pkg::FULL_W-1:0] end_sum;
  logic                        fits;
  logic                        below;
  logic [4:0]                  tail;

  always_comb begin
    sh_lo = 4'(blda_pkg::GOB_ROWS_LOG2) + 4'(cfg.gob_stack_log2);
    sh_hi = 5'(blda_pkg::GOB_BYTES_LOG2) + 5'(cfg.gob_stack_log2);

    // Stage 1: row index and GOB-local offset
    b1_zhy_nxt = blda_pkg::ZHY_W'(pop_data.zh) + blda_pkg::ZHY_W'(pop_data.block_y);
    b1_yq_nxt  = blda_pkg::YQ_W'(pop_data.block_y >> sh_lo);
    ymask      = (blda_pkg::YQ_W'(1) << cfg.gob_stack_log2) - blda_pkg::YQ_W'(1);
    ymid       = pop_data.block_y[13:3] & ymask;
    term2      = blda_pkg::GOB_W'(pop_data.xb[blda_pkg::XB_W-1:blda_pkg::GOB_ROW_LOG2]) << sh_hi;
    term3      = blda_pkg::GOB_W'(ymid) << blda_pkg::GOB_BYTES_LOG2;
    low9       = {pop_data.xb[5], pop_data.block_y[2:1], pop_data.xb[4],
                  pop_data.block_y[0], pop_data.xb[3:0]};
    b1_gob_nxt = term2 | term3 | blda_pkg::GOB_W'(low9);

    // Stage 2: products
    b2_dst_m_nxt   = b1_zhy_r * blda_pkg::LIN_W'(geom.wb);
    b2_pitch_m_nxt = b1_zhy_r * blda_pkg::LIN_W'(geom.pitch);
    b2_slab_m_nxt  = blda_pkg::SLAB_W'(b1_z_r) * blda_pkg::SLAB_W'(geom.slice_size);
    b2_yg_m_nxt    = blda_pkg::YG_W'(b1_yq_r) * blda_pkg::YG_W'(geom.gpr);

    // Stage 3: full-precision addresses
    ygs = blda_pkg::FULL_W'(b2_yg_m_r) << sh_hi;
    if (cfg.layout_mode == blda_pkg::LAYOUT_PITCH) begin
      b3_src_nxt = blda_pkg::FULL_W'(b2_pitch_m_r) + blda_pkg::FULL_W'(b2_xb_r);
    end else begin
      b3_src_nxt = blda_pkg::FULL_W'(b2_slab_m_r) + ygs + blda_pkg::FULL_W'(b2_gob_r);
    end
    b3_dst_nxt = blda_pkg::FULL_W'(b2_dst_m_r) + blda_pkg::FULL_W'(b2_xb_r);

    // Result: source bounds and copy size
    size_ext = blda_pkg::FULL_W'(cfg.source_bytes);
    end_sum  = b3_src_r + blda_pkg::FULL_W'(cfg.bytes_per_block);
    fits     = end_sum <= size_ext;
    below    = b3_src_r < size_ext;
    tail     = cfg.source_bytes[4:0] - b3_src_r[4:0];

    out_data_nxt = '0;
    if (b3_ok_r) begin
      out_data_nxt.src_address = b3_src_r[blda_pkg::ADDR_FIELD_W-1:0] & ADDR_MASK;
      out_data_nxt.dst_address = b3_dst_r[blda_pkg::ADDR_FIELD_W-1:0] & ADDR_MASK;
      if (fits) begin
        out_data_nxt.copy_bytes = cfg.bytes_per_block;
      end else if ((cfg.layout_mode == blda_pkg::LAYOUT_PITCH) && below) begin
        out_data_nxt.copy_bytes = tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r       <= 1'b0;
      b2_v_r       <= 1'b0;
      b3_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      b1_v_r       <= pop_valid;
      b2_v_r       <= b1_v_r;
      b3_v_r       <= b2_v_r;
      out_strobe_r <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b1_ok_r      <= pop_data.in_range;
    b1_zhy_r     <= b1_zhy_nxt;
    b1_yq_r      <= b1_yq_nxt;
    b1_z_r       <= pop_data.slice_z;
    b1_xb_r      <= pop_data.xb;
    b1_gob_r     <= b1_gob_nxt;

    b2_ok_r      <= b1_ok_r;
    b2_dst_m_r   <= b2_dst_m_nxt;
    b2_pitch_m_r <= b2_pitch_m_nxt;
    b2_slab_m_r  <= b2_slab_m_nxt;
    b2_yg_m_r    <= b2_yg_m_nxt;
    b2_xb_r      <= b1_xb_r;
    b2_gob_r     <= b1_gob_r;

    b3_ok_r      <= b2_ok_r;
    b3_src_r     <= b3_src_nxt;
    b3_dst_r     <= b3_dst_nxt;

    out_data_r   <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ----- design/block_linear_deswizzle_address.sv -----
// Block-linear / pitch-linear deswizzle address generator, top level.
// Depends on blda_pkg, blda_cfg, blda_front, blda_queue and blda_back.
//
// Takes one request per clock (start high, busy low) and returns exactly one
// result per request, in order, marked by out_strobe for a single cycle once
// it has passed the front end, the queue and the back-end pipeline. The
// receiver cannot stall the block: the back end retires one request every
// cycle through its multiplier pipeline, so the four-entry request queue
// never fills and busy stays low in normal use. Derived surface geometry is
// registered; write the registers only with no requests in flight.
`timescale 1ns / 1ps

module block_linear_deswizzle_address #(
  parameter int ADDR_BITS = blda_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [blda_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [blda_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             start,
  output logic                             busy,
  input  blda_pkg::in_item_t               in_data,
  output logic                             out_strobe,
  output blda_pkg::out_item_t              out_data
);

  blda_pkg::cfg_t               cfg;
  blda_pkg::geom_t              geom;
  logic [blda_pkg::Q_CNT_W-1:0] q_count;
  logic                         push;
  blda_pkg::q_item_t            push_data;
  logic                         pop_valid;
  blda_pkg::q_item_t            pop_data;

  blda_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .geom      (geom)
  );

  blda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg       (cfg),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  blda_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .q_count   (q_count),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  blda_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .geom       (geom),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ----- tb/sv/deswizzle_addr_checker.sv -----
// Checker for the block-linear deswizzle address generator: tracks register
// writes, predicts each accepted request and compares the strobed results.
// Depends on blda_pkg; instantiated by tb_block_linear_deswizzle_address.
`timescale 1ns / 1ps

module deswizzle_addr_checker
  import blda_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   start,
  input  logic                   busy,
  input  in_item_t               in_data,
  input  logic                   out_strobe,
  input  out_item_t              out_data,
  output int                     fail_count,
  output int                     pending,
  output int                     checked,
  output int                     copying
);

  cfg_t      surface_regs;
  out_item_t expected_blocks[$];
  int        mismatch_count = 0;
  int        result_count = 0;
  int        copy_count = 0;

  function automatic out_item_t locate_block(cfg_t c, in_item_t it);
    logic [63:0] x, y, z, w, h, slices, bpb, size;
    logic [63:0] gh, rows, row_bytes, gpr, slice_size, xb, offs;
    logic [63:0] pitch, src, dst, cp;
    out_item_t   r;
    x = 64'(it.block_x);
    y = 64'(it.block_y);
    z = 64'(it.slice_z);
    w = 64'(c.width_blocks);
    h = 64'(c.height_blocks);
    slices = (c.slice_count == 0) ? 64'd1 : 64'(c.slice_count);
    bpb = 64'(c.bytes_per_block);
    size = 64'(c.source_bytes);
    r = '0;
    if (x >= w || y >= h || z >= slices) return r;
    dst = (z * h + y) * w * bpb + x * bpb;
    if (c.layout_mode == LAYOUT_BLOCK) begin
      gh = 64'd1 << c.gob_stack_log2;
      rows = 64'd8 * gh;
      row_bytes = ((w * bpb + 64'd63) / 64'd64) * 64'd64;
      gpr = row_bytes / 64'd64;
      slice_size = row_bytes * (((h + rows - 64'd1) / rows) * rows);
      xb = x * bpb;
      offs = (y / rows) * 64'd512 * gh * gpr
           + (xb / 64'd64) * 64'd512 * gh
           + ((y % rows) / 64'd8) * 64'd512
           + ((xb % 64'd64) / 64'd32) * 64'd256
           + ((y % 64'd8) / 64'd2) * 64'd64
           + ((xb % 64'd32) / 64'd16) * 64'd32
           + (y % 64'd2) * 64'd16
           + (xb % 64'd16);
      src = z * slice_size + offs;
      cp = (src + bpb <= size) ? bpb : 64'd0;
    end else begin
      pitch = ((w * bpb + 64'd31) / 64'd32) * 64'd32;
      src = (z * h + y) * pitch + x * bpb;
      if (src < size) begin
        cp = ((size - src) < bpb) ? (size - src) : bpb;
      end else begin
        cp = 64'd0;
      end
    end
    r.src_address = src[ADDR_FIELD_W-1:0];
    r.dst_address = dst[ADDR_FIELD_W-1:0];
    r.copy_bytes  = cp[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      surface_regs = '{LAYOUT_BLOCK, 15'd1, 15'd1, 12'd1, 5'd4, 3'd0, 44'd0};
      expected_blocks.delete();
    end else begin
      if (out_strobe === 1'b1) begin
        result_count++;
        if (expected_blocks.size() == 0) begin
          if (mismatch_count < 10)
            $display("result %0d arrived with no request outstanding: src %h dst %h copy %0d",
                     result_count, out_data.src_address, out_data.dst_address,
                     out_data.copy_bytes);
          mismatch_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (want.copy_bytes != 0) copy_count++;
          if (out_data.src_address !== want.src_address ||
              out_data.dst_address !== want.dst_address ||
              out_data.copy_bytes !== want.copy_bytes) begin
            if (mismatch_count < 10)
              $display("result %0d: expected src %h dst %h copy %0d, got src %h dst %h copy %0d",
                       result_count, want.src_address, want.dst_address, want.copy_bytes,
                       out_data.src_address, out_data.dst_address, out_data.copy_bytes);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) expected_blocks.push_back(locate_block(surface_regs, in_data));
      if (cfg_we) begin
        case (cfg_index)
          REG_LAYOUT_MODE:     surface_regs.layout_mode     = cfg_wdata[0];
          REG_WIDTH_BLOCKS:    surface_regs.width_blocks    = cfg_wdata[14:0];
          REG_HEIGHT_BLOCKS:   surface_regs.height_blocks   = cfg_wdata[14:0];
          REG_SLICE_COUNT:     surface_regs.slice_count     = cfg_wdata[11:0];
          REG_BYTES_PER_BLOCK: surface_regs.bytes_per_block = cfg_wdata[4:0];
          REG_GOB_STACK_LOG2:  surface_regs.gob_stack_log2  = cfg_wdata[2:0];
          REG_SOURCE_BYTES:    surface_regs.source_bytes    = cfg_wdata[43:0];
          default: ;
        endcase
      end
    end
    fail_count <= mismatch_count;
    pending    <= expected_blocks.size();
    checked    <= result_count;
    copying    <= copy_count;
  end

endmodule

// ----- tb/sv/tb_block_linear_deswizzle_address.sv -----
// Testbench top for block_linear_deswizzle_address: drives register settings
// and block requests, and gives the verdict from deswizzle_addr_checker.
// Depends on blda_pkg, the block and deswizzle_addr_checker.
`timescale 1ns / 1ps

module tb_block_linear_deswizzle_address;
  import blda_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_REQUESTS = 120;
  localparam int DRAIN_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 20;
  localparam int CYCLE_LIMIT    = 200000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   start = 1'b0;
  logic                   busy;
  in_item_t               in_data = '0;
  logic                   out_strobe;
  out_item_t              out_data;

  int   fail_count, pending, checked, copying;
  int   cycles = 0;
  int   requests_sent = 0;
  int   settings_used = 0;
  cfg_t surface = '{LAYOUT_BLOCK, 15'd1, 15'd1, 12'd1, 5'd4, 3'd0, 44'd0};

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  block_linear_deswizzle_address u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  deswizzle_addr_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .copying    (copying)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [43:0] rand44();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[43:0];
  endfunction

  function automatic cfg_t make_surface(logic mode, int unsigned w, int unsigned h,
                                        int unsigned sl, int unsigned bpb, int unsigned gsl,
                                        logic [43:0] src);
    cfg_t s;
    s.layout_mode     = mode;
    s.width_blocks    = 15'(w);
    s.height_blocks   = 15'(h);
    s.slice_count     = 12'(sl);
    s.bytes_per_block = 5'(bpb);
    s.gob_stack_log2  = 3'(gsl);
    s.source_bytes    = src;
    return s;
  endfunction

  function automatic logic [14:0] pick_extent();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 15'd0;
    if (r == 1) return 15'd16384;
    if (r == 2) return 15'($urandom_range(1, 32767));
    if (r < 8) return 15'($urandom_range(1, 16));
    return 15'($urandom_range(1, 300));
  endfunction

  function automatic cfg_t draw_surface();
    cfg_t        s;
    int unsigned r;
    logic [63:0] w, h, b, eff, rows, span;
    s.layout_mode   = 1'($urandom_range(0, 1));
    s.width_blocks  = pick_extent();
    s.height_blocks = pick_extent();
    r = $urandom_range(0, 11);
    s.slice_count = (r == 0) ? 12'd0 : (r == 1) ? 12'd2048 : (r == 2) ? 12'd4095 :
                    (r == 3) ? 12'($urandom_range(1, 4095)) : 12'($urandom_range(1, 6));
    r = $urandom_range(0, 19);
    s.bytes_per_block = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31)) :
                        5'($urandom_range(1, 16));
    s.gob_stack_log2 = 3'($urandom_range(0, 7));
    w = 64'(s.width_blocks);
    h = 64'(s.height_blocks);
    b = 64'(s.bytes_per_block);
    eff = (s.slice_count == 0) ? 64'd1 : 64'(s.slice_count);
    if (s.layout_mode == LAYOUT_BLOCK) begin
      rows = 64'd8 << s.gob_stack_log2;
      span = ((w * b + 64'd63) / 64'd64 * 64'd64) * ((h + rows - 64'd1) / rows * rows) * eff;
    end else begin
      span = ((w * b + 64'd31) / 64'd32 * 64'd32) * h * eff;
    end
    r = $urandom_range(0, 19);
    if (r == 0) s.source_bytes = 44'd0;
    else if (r == 1) s.source_bytes = '1;
    else if (r < 4) s.source_bytes = rand44();
    else s.source_bytes = 44'(span * $urandom_range(50, 110) / 100 + $urandom_range(0, 63));
    return s;
  endfunction

  function automatic in_item_t pick_block(cfg_t s);
    in_item_t    it;
    int unsigned xmax, ymax, zmax, eff, r;
    xmax = (s.width_blocks == 0) ? 0 : (s.width_blocks > 16384) ? 16383 : s.width_blocks - 1;
    ymax = (s.height_blocks == 0) ? 0 : (s.height_blocks > 16384) ? 16383 : s.height_blocks - 1;
    eff  = (s.slice_count == 0) ? 1 : s.slice_count;
    zmax = (eff > 2048) ? 2047 : eff - 1;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      it.block_x = 14'($urandom_range(0, xmax));
      it.block_y = 14'($urandom_range(0, ymax));
      it.slice_z = 11'($urandom_range(0, zmax));
    end else if (r < 90) begin
      it.block_x = 14'(xmax + $urandom_range(0, 1));
      it.block_y = 14'(ymax + $urandom_range(0, 1));
      it.slice_z = 11'(zmax + $urandom_range(0, 1));
    end else begin
      it.block_x = 14'($urandom());
      it.block_y = 14'($urandom());
      it.slice_z = 11'($urandom());
    end
    return it;
  endfunction

  task automatic send_block(input in_item_t it);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) begin
      in_data <= in_item_t'(rand44());
      @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [43:0] value,
                           input int bits);
    logic [43:0] mask;
    mask = (bits >= 44) ? '1 : ((44'd1 << bits) - 44'd1);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (rand44() & ~mask) | (value & mask);
    @(negedge clk);
  endtask

  task automatic apply_surface(input cfg_t s);
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(REG_LAYOUT_MODE, 44'(s.layout_mode), 1);
    write_reg(REG_WIDTH_BLOCKS, 44'(s.width_blocks), 15);
    write_reg(REG_HEIGHT_BLOCKS, 44'(s.height_blocks), 15);
    write_reg(REG_SLICE_COUNT, 44'(s.slice_count), 12);
    write_reg(REG_BYTES_PER_BLOCK, 44'(s.bytes_per_block), 5);
    write_reg(REG_GOB_STACK_LOG2, 44'(s.gob_stack_log2), 3);
    write_reg(REG_SOURCE_BYTES, s.source_bytes, 44);
    write_reg(REG_UNUSED, rand44(), 44);
    cfg_we <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    surface = s;
    settings_used++;
  endtask

  initial begin
    int ph, k;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);

    // reset geometry: one block, empty source
    send_block('{14'd0, 14'd0, 11'd0});
    send_block('{14'd1, 14'd0, 11'd0});
    send_block('{14'd16383, 14'd16383, 11'd2047});

    apply_surface(make_surface(LAYOUT_BLOCK, 16384, 16384, 2048, 16, 5, '1));
    send_block('{14'd0, 14'd0, 11'd0});
    send_block('{14'd16383, 14'd16383, 11'd2047});
    send_block('{14'd16383, 14'd0, 11'd0});
    send_block('{14'd0, 14'd16383, 11'd0});
    send_block('{14'd0, 14'd0, 11'd2047});
    send_block('{14'd5, 14'd9, 11'd3});

    // pitch rows of 320 bytes; the last block straddles the end of the source
    apply_surface(make_surface(LAYOUT_PITCH, 100, 50, 0, 3, 0, 44'd15979));
    send_block('{14'd99, 14'd49, 11'd0});
    send_block('{14'd100, 14'd0, 11'd0});
    send_block('{14'd0, 14'd50, 11'd0});
    send_block('{14'd0, 14'd0, 11'd1});
    send_block('{14'd0, 14'd0, 11'd0});

    apply_surface(make_surface(LAYOUT_BLOCK, 0, 8, 1, 0, 7, '1));
    send_block('{14'd0, 14'd0, 11'd0});

    apply_surface(make_surface(LAYOUT_BLOCK, 32767, 32767, 4095, 31, 6, '1));
    send_block('{14'd16383, 14'd16383, 11'd2047});
    send_block('{14'd7, 14'd13, 11'd1});

    apply_surface(make_surface(LAYOUT_PITCH, 10, 10, 2, 0, 2, 44'd1000));
    send_block('{14'd3, 14'd3, 11'd1});

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_surface(draw_surface());
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        if (ph < RANDOM_PHASES - 2 && $urandom_range(0, 4) == 0)
          idle_cycles($urandom_range(1, 10));
        if (ph == 4 && k == PHASE_REQUESTS / 2) drain();
        send_block(pick_block(surface));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d block requests over %0d register settings;",
             requests_sent, settings_used);
    $display("%0d results compared, %0d of them with bytes to copy.", checked, copying);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/blda_pkg.sv
design/blda_cfg.sv
design/blda_front.sv
design/blda_queue.sv
design/blda_back.sv
design/block_linear_deswizzle_address.sv
tb/sv/deswizzle_addr_checker.sv
tb/sv/tb_block_linear_deswizzle_address.sv
